>>> sv/pvp_pkg.sv
// Shared types, constants and the divider step function for the vertex projection block.
// No dependencies; every other file of the block imports this package.
package pvp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 64;
	localparam int CFG_ADDR_W    = 2;

	// divider: 32 quotient bits, four restoring steps per stage
	localparam int DIV_STEPS     = 4;
	localparam int DIV_STAGES    = DATA_W / DIV_STEPS;
	localparam int FRONT_STAGES  = 3;
	localparam int NUM_STAGES    = FRONT_STAGES + DIV_STAGES + 1;
	localparam int NUM_LANES     = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_X_SCALE      = 2'd0,
		REG_Y_SCALE      = 2'd1,
		REG_DEPTH_SCALE  = 2'd2,
		REG_DEPTH_OFFSET = 2'd3
	} cfg_reg_t;

	// one lane as handed from the front end to the divider
	typedef struct packed {
		logic [PROD_W-1:0] mag;
		logic [DATA_W-1:0] dvs;
		logic              neg;
		logic              ovf;
	} lane_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] low;
	} div_state_t;

	// advance one restoring divide by DIV_STEPS quotient bits
	function automatic div_state_t div_steps(div_state_t st, logic [DATA_W-1:0] dvs);
		logic [DATA_W:0] t;
		div_state_t      o;
		o = st;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {o.rem, o.low[DATA_W-1]};
			if (t >= {1'b0, dvs}) begin
				o.rem = DATA_W'(t - {1'b0, dvs});
				o.low = {o.low[DATA_W-2:0], 1'b1};
			end else begin
				o.rem = t[DATA_W-1:0];
				o.low = {o.low[DATA_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

>>> sv/pvp_front.sv
// Front end: matrix products, depth offset sum and divide set-up (magnitudes, sign, overflow).
// Depends on pvp_pkg.
module pvp_front import pvp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic [FRONT_STAGES-1:0]         en,
	input  logic signed [DATA_W-1:0]        x_scale,
	input  logic signed [DATA_W-1:0]        y_scale,
	input  logic signed [DATA_W-1:0]        depth_scale,
	input  logic signed [DATA_W-1:0]        depth_offset,
	input  logic signed [DATA_W-1:0]        vertex_x,
	input  logic signed [DATA_W-1:0]        vertex_y,
	input  logic signed [DATA_W-1:0]        vertex_z,
	output lane_t                           lane [NUM_LANES]
);

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [DATA_W-1:0] off_s1, z_s1, z_s2;
	logic signed [PROD_W-1:0] clip_s2 [NUM_LANES];
	logic [DATA_W-1:0]        dvs_c;
	logic [PROD_W-1:0]        mag_c [NUM_LANES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1  <= x_scale * vertex_x;
			py_s1  <= y_scale * vertex_y;
			pz_s1  <= depth_scale * vertex_z;
			off_s1 <= depth_offset;
			z_s1   <= vertex_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			clip_s2[0] <= px_s1;
			clip_s2[1] <= py_s1;
			clip_s2[2] <= pz_s1 + ($signed({{(PROD_W-DATA_W){off_s1[DATA_W-1]}}, off_s1})
				<<< FRAC_BITS);
			z_s2       <= z_s1;
		end
	end

	// zero depth divides by one unit of the fixed-point format
	always_comb begin
		if (z_s2 == '0)
			dvs_c = DATA_W'(1) << FRAC_BITS;
		else if (z_s2[DATA_W-1])
			dvs_c = DATA_W'(-z_s2);
		else
			dvs_c = z_s2;
		for (int i = 0; i < NUM_LANES; i++)
			mag_c[i] = clip_s2[i][PROD_W-1] ? PROD_W'(-clip_s2[i]) : clip_s2[i];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				lane[i].mag <= mag_c[i];
				lane[i].dvs <= dvs_c;
				lane[i].neg <= clip_s2[i][PROD_W-1] ^ z_s2[DATA_W-1];
				lane[i].ovf <= mag_c[i][PROD_W-1:DATA_W] >= dvs_c;
			end
		end
	end

endmodule

>>> sv/pvp_div.sv
// One lane of the pipelined restoring divider with signed saturation at the output.
// Depends on pvp_pkg.
module pvp_div import pvp_pkg::*; (
	input  logic                    clk,
	input  logic [DIV_STAGES:0]     en,
	input  lane_t                   lane,
	output logic [DATA_W-1:0]       res
);

	div_state_t        st_s  [DIV_STAGES+1];
	logic [DATA_W-1:0] dvs_s [DIV_STAGES+1];
	logic              neg_s [DIV_STAGES+1];
	logic              ovf_s [DIV_STAGES+1];
	logic [DATA_W-1:0] q;

	// remainder starts from the high half, which is below the divisor unless overflowed
	assign st_s[0].rem = lane.mag[PROD_W-1:DATA_W];
	assign st_s[0].low = lane.mag[DATA_W-1:0];
	assign dvs_s[0]    = lane.dvs;
	assign neg_s[0]    = lane.neg;
	assign ovf_s[0]    = lane.ovf;

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[k-1]) begin
				st_s[k]  <= div_steps(st_s[k-1], dvs_s[k-1]);
				dvs_s[k] <= dvs_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign q = st_s[DIV_STAGES].low;

	always_ff @(posedge clk) begin
		if (en[DIV_STAGES]) begin
			if (neg_s[DIV_STAGES]) begin
				if (ovf_s[DIV_STAGES] || q > {1'b1, {(DATA_W-1){1'b0}}})
					res <= {1'b1, {(DATA_W-1){1'b0}}};
				else
					res <= DATA_W'(-q);
			end else begin
				if (ovf_s[DIV_STAGES] || q[DATA_W-1])
					res <= {1'b0, {(DATA_W-1){1'b1}}};
				else
					res <= q;
			end
		end
	end

endmodule

>>> sv/perspective_vertex_projection.sv
// Top level of the perspective vertex projection: configuration registers, stage valids, lanes.
// Depends on pvp_pkg, pvp_front and pvp_div.
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_tvalid / s_tready   | tdata: vertex_x, vertex_y, vertex_z
//  m_      | out       | m_tvalid / m_tready   | tdata: ndc_x, ndc_y, ndc_z; tuser: divided
//  cfg_    | in        | cfg_we                | cfg_addr, cfg_wdata
//
// One item enters per clock while s_tready is high; each passes twelve register stages in order
// before it is offered on m_: three front stages (products, offset sum, divide set-up),
// eight divider stages of four quotient bits each, and one saturation stage that is the
// output register.
// Reset clears the stage valids and loads the matrix terms with 1.0, 1.0, 1.0 and 0.
// A stall at the output holds only the stages that are full behind it; empty stages
// still advance, so bubbles close up and input keeps being taken while any stage is free.
module perspective_vertex_projection import pvp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [3*DATA_W-1:0]         s_tdata,   // vertex_x, vertex_y, vertex_z
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [3*DATA_W-1:0]         m_tdata,   // ndc_x, ndc_y, ndc_z
	output logic                        m_tuser,   // divided
	input  logic                        cfg_we,
	input  logic [CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [DATA_W-1:0]           cfg_wdata
);

	logic signed [DATA_W-1:0] x_scale_q, y_scale_q, depth_scale_q, depth_offset_q;
	logic [NUM_STAGES-1:0]    valid_q;
	logic [NUM_STAGES-1:0]    flag_q;
	logic [NUM_STAGES-1:0]    en;
	lane_t                    lane [NUM_LANES];
	logic [DATA_W-1:0]        res  [NUM_LANES];

	// matrix terms; the user must write them only while the pipeline is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q      <= DATA_W'(1) << FRAC_BITS;
			y_scale_q      <= DATA_W'(1) << FRAC_BITS;
			depth_scale_q  <= DATA_W'(1) << FRAC_BITS;
			depth_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_X_SCALE:      x_scale_q      <= cfg_wdata;
				REG_Y_SCALE:      y_scale_q      <= cfg_wdata;
				REG_DEPTH_SCALE:  depth_scale_q  <= cfg_wdata;
				REG_DEPTH_OFFSET: depth_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the stage after it loads
	always_comb begin
		en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--)
			en[k] = !valid_q[k] || en[k+1];
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0])
				valid_q[0] <= s_tvalid;
			for (int k = 1; k < NUM_STAGES; k++)
				if (en[k])
					valid_q[k] <= valid_q[k-1];
		end
	end

	// divided flag travels alongside the data
	always_ff @(posedge clk) begin
		if (en[0])
			flag_q[0] <= s_tdata[3*DATA_W-1:2*DATA_W] != '0;
		for (int k = 1; k < NUM_STAGES; k++)
			if (en[k])
				flag_q[k] <= flag_q[k-1];
	end

	pvp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk          (clk),
		.en           (en[FRONT_STAGES-1:0]),
		.x_scale      (x_scale_q),
		.y_scale      (y_scale_q),
		.depth_scale  (depth_scale_q),
		.depth_offset (depth_offset_q),
		.vertex_x     (s_tdata[DATA_W-1:0]),
		.vertex_y     (s_tdata[2*DATA_W-1:DATA_W]),
		.vertex_z     (s_tdata[3*DATA_W-1:2*DATA_W]),
		.lane         (lane)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		pvp_div u_div (
			.clk  (clk),
			.en   (en[NUM_STAGES-1:FRONT_STAGES]),
			.lane (lane[i]),
			.res  (res[i])
		);
		assign m_tdata[i*DATA_W +: DATA_W] = res[i];
	end

	assign m_tvalid = valid_q[NUM_STAGES-1];
	assign m_tuser  = flag_q[NUM_STAGES-1];

	// an accepted item occupies the first stage next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_q[0])
		else $error("accepted item not held in first stage");

	// a full pipeline under output stall takes nothing
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_q) && !m_tready |-> !s_tready)
		else $error("input taken while pipeline full and stalled");

	// an empty last stage lets every stage move
	a_empty_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[NUM_STAGES-1] |-> s_tready)
		else $error("input blocked with empty output stage");

endmodule
